// File: hdl/tssc_pkg.sv
package tssc_pkg;

	// per-tensor result codes
	typedef enum logic [3:0] {
		ST_EXACT     = 4'd0,
		ST_PADDED    = 4'd1,
		ST_ZERO_DIM  = 4'd2,
		ST_COUNT_OVF = 4'd3,
		ST_UNKNOWN   = 4'd4,
		ST_REFUSED   = 4'd5,
		ST_BYTE_OVF  = 4'd6,
		ST_TOTAL_OVF = 4'd7,
		ST_SKIPPED   = 4'd8
	} status_t;

	typedef enum logic [1:0] {
		FS_NONE      = 2'd0,
		FS_OK        = 2'd1,
		FS_MALFORMED = 2'd2,
		FS_REFUSED   = 2'd3
	} file_state_t;

	typedef enum logic [1:0] {
		TC_UNKNOWN,
		TC_SCALAR,
		TC_BLOCK,
		TC_REFUSED
	} type_class_t;

	// which 32-bit halves feed the shared multiplier
	typedef enum logic [1:0] {
		MS_NONE,
		MS_LL,
		MS_HL,
		MS_LH
	} mul_sel_t;

	typedef enum logic [1:0] {
		AS_NONE,
		AS_LO,
		AS_HI
	} acc_sel_t;

	typedef enum logic {
		BS_DIM,
		BS_EACH
	} b_sel_t;

	typedef enum logic [2:0] {
		CK_NONE,
		CK_DIM,
		CK_DIM_OVF,
		CK_TYPE,
		CK_BYTE_OVF,
		CK_TOTAL
	} check_t;

	localparam int PC_W        = 4;
	localparam int EACH_W      = 6;
	localparam int BLOCK_SHIFT = 5;

	typedef logic [PC_W-1:0] pc_t;

	localparam pc_t PC_DIM      = 4'd0;
	localparam pc_t PC_DIM_HL   = 4'd1;
	localparam pc_t PC_DIM_LH   = 4'd2;
	localparam pc_t PC_DIM_ACC  = 4'd3;
	localparam pc_t PC_DIM_END  = 4'd4;
	localparam pc_t PC_TYPE     = 4'd5;
	localparam pc_t PC_BYTE_LL  = 4'd6;
	localparam pc_t PC_BYTE_HL  = 4'd7;
	localparam pc_t PC_BYTE_LH  = 4'd8;
	localparam pc_t PC_BYTE_ACC = 4'd9;
	localparam pc_t PC_BYTE_END = 4'd10;
	localparam pc_t PC_TOTAL    = 4'd11;

	typedef struct packed {
		mul_sel_t mul;
		acc_sel_t acc;
		b_sel_t   bsel;
		check_t   check;
		pc_t      target;
	} uword_t;

	typedef struct packed {
		type_class_t       cls;
		logic [EACH_W-1:0] each;
	} geom_t;

	// control store
	function automatic uword_t ucode(pc_t pc);
		uword_t w;
		unique case (pc)
			PC_DIM:      w = '{MS_LL,   AS_NONE, BS_DIM,  CK_DIM,      PC_TYPE};
			PC_DIM_HL:   w = '{MS_HL,   AS_LO,   BS_DIM,  CK_NONE,     PC_DIM};
			PC_DIM_LH:   w = '{MS_LH,   AS_HI,   BS_DIM,  CK_NONE,     PC_DIM};
			PC_DIM_ACC:  w = '{MS_NONE, AS_HI,   BS_DIM,  CK_NONE,     PC_DIM};
			PC_DIM_END:  w = '{MS_NONE, AS_NONE, BS_DIM,  CK_DIM_OVF,  PC_DIM};
			PC_TYPE:     w = '{MS_NONE, AS_NONE, BS_EACH, CK_TYPE,     PC_DIM};
			PC_BYTE_LL:  w = '{MS_LL,   AS_NONE, BS_EACH, CK_NONE,     PC_DIM};
			PC_BYTE_HL:  w = '{MS_HL,   AS_LO,   BS_EACH, CK_NONE,     PC_DIM};
			PC_BYTE_LH:  w = '{MS_LH,   AS_HI,   BS_EACH, CK_NONE,     PC_DIM};
			PC_BYTE_ACC: w = '{MS_NONE, AS_HI,   BS_EACH, CK_NONE,     PC_DIM};
			PC_BYTE_END: w = '{MS_NONE, AS_NONE, BS_EACH, CK_BYTE_OVF, PC_DIM};
			PC_TOTAL:    w = '{MS_NONE, AS_NONE, BS_EACH, CK_TOTAL,    PC_DIM};
			default:     w = '{MS_NONE, AS_NONE, BS_DIM,  CK_NONE,     PC_DIM};
		endcase
		return w;
	endfunction

	// storage geometry per type id
	function automatic geom_t classify(logic [31:0] id);
		geom_t g;
		case (id) inside
			32'd0, 32'd26:         g = '{TC_SCALAR,  6'd4};
			32'd1, 32'd25, 32'd30: g = '{TC_SCALAR,  6'd2};
			32'd24:                g = '{TC_SCALAR,  6'd1};
			32'd27, 32'd28:        g = '{TC_SCALAR,  6'd8};
			32'd2:                 g = '{TC_BLOCK,   6'd18};
			32'd3:                 g = '{TC_BLOCK,   6'd20};
			32'd6:                 g = '{TC_BLOCK,   6'd22};
			32'd7:                 g = '{TC_BLOCK,   6'd24};
			32'd8:                 g = '{TC_BLOCK,   6'd34};
			32'd9:                 g = '{TC_BLOCK,   6'd40};
			[32'd10:32'd23], 32'd29, 32'd34, 32'd35, 32'd39:
				g = '{TC_REFUSED, 6'd0};
			default:               g = '{TC_UNKNOWN, 6'd0};
		endcase
		return g;
	endfunction

endpackage

// File: hdl/tensor_storage_size_checker.sv
// tensor storage size checker: one descriptor word in (type id and up to four
// dimension lengths), one result word out. the dimensions are multiplied into
// an element count, the type is looked up in a fixed geometry table and the
// storage bytes are added to a running per-file total; the first error stops
// the file and later words report skipped until one raises start_file.
// a small microcoded sequencer drives one shared 32x32 multiplier; a 64-bit
// product with overflow check takes three partial products for each used
// dimension, and an early error or a skipped word ends the word at once.
// one word is worked on at a time; a new word is taken as soon as the last
// one has been written to the output register, even while that result still
// waits to be taken.
module tensor_storage_size_checker
	import tssc_pkg::*;
#(
	parameter int MAX_DIMS   = 4,
	parameter int COUNT_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        start_file,
	input  logic [31:0] type_id,
	input  logic [2:0]  dim_count,
	input  logic [63:0] dim_a,
	input  logic [63:0] dim_b,
	input  logic [63:0] dim_c,
	input  logic [63:0] dim_d,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  tensor_status,
	output logic [63:0] tensor_bytes,
	output logic [63:0] total_bytes,
	output logic [31:0] checked_count,
	output logic [31:0] known_count,
	output logic [31:0] refused_count,
	output logic [31:0] first_refused_type,
	output logic [1:0]  file_status
);

	// dimension slots actually held; extra dimension inputs are never read
	localparam int NUM_DIMS = (MAX_DIMS < 4) ? MAX_DIMS : 4;
	localparam int REM_W    = $clog2(NUM_DIMS + 1);
	localparam int TALLY_W  = (COUNT_BITS < 32) ? COUNT_BITS : 32;

	function automatic logic [TALLY_W-1:0] tally_inc(logic [TALLY_W-1:0] v);
		return (&v) ? v : v + TALLY_W'(1);
	endfunction

	// sequencer control
	logic   busy_q;
	pc_t    pc_q;
	logic   out_valid_q;
	uword_t uw;

	// per-file state
	logic [63:0]        total_q;
	logic [TALLY_W-1:0] checked_q;
	logic [TALLY_W-1:0] known_q;
	logic [TALLY_W-1:0] refused_q;
	logic [31:0]        first_q;
	file_state_t        fs_q;

	// working registers
	logic [63:0]       dims_q [NUM_DIMS];
	logic [63:0]       in_dims [4];
	logic [REM_W-1:0]  rem_q;
	logic [31:0]       type_q;
	logic              skip_q;
	logic [63:0]       work_q;
	logic [63:0]       prod_q;
	logic [63:0]       acc_q;
	logic              ovf_q;
	logic [EACH_W-1:0] each_q;
	logic              pad_q;

	// result register
	status_t            status_q;
	logic [63:0]        bytes_q;
	logic [63:0]        o_total_q;
	logic [TALLY_W-1:0] o_checked_q;
	logic [TALLY_W-1:0] o_known_q;
	logic [TALLY_W-1:0] o_refused_q;
	logic [31:0]        o_first_q;
	file_state_t        o_fs_q;

	// datapath and next-state signals
	logic               in_acc;
	logic               adv;
	logic [63:0]        b_op;
	logic [31:0]        mul_a;
	logic [31:0]        mul_b;
	logic [32:0]        hi_sum;
	logic [64:0]        total_sum;
	geom_t              geom;
	logic [63:0]        units;
	logic               fin;
	logic               jump;
	logic               work_ld_acc;
	logic               work_ld_units;
	logic               shift_dims;
	status_t            st_n;
	logic [63:0]        bytes_n;
	logic [63:0]        total_n;
	logic [TALLY_W-1:0] checked_n;
	logic [TALLY_W-1:0] known_n;
	logic [TALLY_W-1:0] refused_n;
	logic [31:0]        first_n;
	file_state_t        fs_n;

	assign in_dims[0] = dim_a;
	assign in_dims[1] = dim_b;
	assign in_dims[2] = dim_c;
	assign in_dims[3] = dim_d;

	assign in_ready = !busy_q;
	assign in_acc   = in_valid && !busy_q;

	always_comb begin
		uw     = ucode(pc_q);
		// second operand: current dimension or bytes per unit
		b_op   = (uw.bsel == BS_EACH) ? 64'(each_q) : dims_q[0];
		mul_a  = (uw.mul == MS_HL) ? work_q[63:32] : work_q[31:0];
		mul_b  = (uw.mul == MS_LH) ? b_op[63:32] : b_op[31:0];
		hi_sum = {1'b0, acc_q[63:32]} + {1'b0, prod_q[31:0]};
		geom   = classify(type_q);
		// block types round up to whole 32-element blocks
		if (geom.cls == TC_BLOCK) begin
			units = (work_q >> BLOCK_SHIFT) + 64'(work_q[BLOCK_SHIFT-1:0] != '0);
		end else begin
			units = work_q;
		end
		total_sum = {1'b0, total_q} + {1'b0, work_q};

		fin           = 1'b0;
		jump          = 1'b0;
		work_ld_acc   = 1'b0;
		work_ld_units = 1'b0;
		shift_dims    = 1'b0;
		st_n          = ST_EXACT;
		bytes_n       = '0;
		total_n       = total_q;
		checked_n     = checked_q;
		known_n       = known_q;
		refused_n     = refused_q;
		first_n       = first_q;
		fs_n          = fs_q;

		unique case (uw.check)
			CK_NONE: begin
			end
			CK_DIM: begin
				if (skip_q) begin
					fin  = 1'b1;
					st_n = ST_SKIPPED;
				end else if (rem_q == '0) begin
					jump = 1'b1;
				end else if (dims_q[0] == '0) begin
					fin  = 1'b1;
					st_n = ST_ZERO_DIM;
					fs_n = FS_MALFORMED;
				end
			end
			CK_DIM_OVF: begin
				if (ovf_q) begin
					fin  = 1'b1;
					st_n = ST_COUNT_OVF;
					fs_n = FS_MALFORMED;
				end else begin
					work_ld_acc = 1'b1;
					shift_dims  = 1'b1;
					jump        = 1'b1;
				end
			end
			CK_TYPE: begin
				checked_n = tally_inc(checked_q);
				if (geom.cls == TC_UNKNOWN || geom.cls == TC_REFUSED) begin
					fin       = 1'b1;
					st_n      = (geom.cls == TC_UNKNOWN) ? ST_UNKNOWN : ST_REFUSED;
					refused_n = tally_inc(refused_q);
					first_n   = (first_q == '0) ? type_q : first_q;
					fs_n      = FS_REFUSED;
				end else begin
					work_ld_units = 1'b1;
				end
			end
			CK_BYTE_OVF: begin
				if (ovf_q) begin
					fin       = 1'b1;
					st_n      = ST_BYTE_OVF;
					refused_n = tally_inc(refused_q);
					first_n   = (first_q == '0) ? type_q : first_q;
					fs_n      = FS_REFUSED;
				end else begin
					work_ld_acc = 1'b1;
				end
			end
			CK_TOTAL: begin
				fin = 1'b1;
				if (total_sum[64]) begin
					st_n = ST_TOTAL_OVF;
					fs_n = FS_REFUSED;
				end else begin
					st_n    = pad_q ? ST_PADDED : ST_EXACT;
					bytes_n = work_q;
					total_n = total_sum[63:0];
					known_n = tally_inc(known_q);
				end
			end
			default: begin
			end
		endcase

		// hold the finishing step while the result register is still full
		adv = busy_q && !(fin && out_valid_q && !out_ready);
	end

	// control and per-file state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			pc_q        <= PC_DIM;
			out_valid_q <= 1'b0;
			total_q     <= '0;
			checked_q   <= '0;
			known_q     <= '0;
			refused_q   <= '0;
			first_q     <= '0;
			fs_q        <= FS_NONE;
		end else begin
			if (in_acc) begin
				busy_q <= 1'b1;
				pc_q   <= PC_DIM;
				if (start_file) begin
					total_q   <= '0;
					checked_q <= '0;
					known_q   <= '0;
					refused_q <= '0;
					first_q   <= '0;
					fs_q      <= FS_OK;
				end else if (fs_q == FS_NONE) begin
					fs_q <= FS_OK;
				end
			end else if (adv) begin
				total_q   <= total_n;
				checked_q <= checked_n;
				known_q   <= known_n;
				refused_q <= refused_n;
				first_q   <= first_n;
				fs_q      <= fs_n;
				if (fin) begin
					busy_q <= 1'b0;
					pc_q   <= PC_DIM;
				end else if (jump) begin
					pc_q <= uw.target;
				end else begin
					pc_q <= pc_q + PC_W'(1);
				end
			end

			if (adv && fin) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (in_acc) begin
			type_q <= type_id;
			skip_q <= !start_file && (fs_q == FS_MALFORMED || fs_q == FS_REFUSED);
			work_q <= 64'd1;
			// dimension count saturates at the slots held
			rem_q  <= (dim_count > 3'(NUM_DIMS)) ? REM_W'(NUM_DIMS) : REM_W'(dim_count);
			for (int k = 0; k < NUM_DIMS; k++) begin
				dims_q[k] <= in_dims[k];
			end
		end else if (adv) begin
			if (uw.mul != MS_NONE) begin
				prod_q <= 64'(mul_a) * 64'(mul_b);
			end
			// partial product accumulate with overflow tracking
			if (uw.acc == AS_LO) begin
				acc_q <= prod_q;
				ovf_q <= (work_q[63:32] != '0) && (b_op[63:32] != '0);
			end else if (uw.acc == AS_HI) begin
				acc_q[63:32] <= hi_sum[31:0];
				ovf_q        <= ovf_q || hi_sum[32] || (prod_q[63:32] != '0);
			end
			if (work_ld_acc) begin
				work_q <= acc_q;
			end
			if (work_ld_units) begin
				work_q <= units;
				each_q <= geom.each;
				pad_q  <= (geom.cls == TC_BLOCK) && (work_q[BLOCK_SHIFT-1:0] != '0);
			end
			if (shift_dims) begin
				for (int k = 0; k < NUM_DIMS - 1; k++) begin
					dims_q[k] <= dims_q[k+1];
				end
				rem_q <= rem_q - REM_W'(1);
			end
			if (fin) begin
				status_q    <= st_n;
				bytes_q     <= bytes_n;
				o_total_q   <= total_n;
				o_checked_q <= checked_n;
				o_known_q   <= known_n;
				o_refused_q <= refused_n;
				o_first_q   <= first_n;
				o_fs_q      <= fs_n;
			end
		end
	end

	assign out_valid          = out_valid_q;
	assign tensor_status      = status_q;
	assign tensor_bytes       = bytes_q;
	assign total_bytes        = o_total_q;
	assign checked_count      = 32'(o_checked_q);
	assign known_count        = 32'(o_known_q);
	assign refused_count      = 32'(o_refused_q);
	assign first_refused_type = o_first_q;
	assign file_status        = o_fs_q;

`ifndef SYNTHESIS
	// only an accepted tensor carries bytes
	a_bytes_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tensor_bytes != '0 |->
			(tensor_status == ST_EXACT || tensor_status == ST_PADDED))
		else $error("tensor bytes on a failed tensor");

	// a skipped word only follows a stopped file
	a_skip_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tensor_status == ST_SKIPPED |->
			(file_status == FS_MALFORMED || file_status == FS_REFUSED))
		else $error("skip reported on a running file");

	// every fully accepted tensor was counted first
	a_known_le_checked: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> known_count <= checked_count)
		else $error("known count above checked count");

	// the sequencer only goes idle by writing a result
	a_done_writes: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> out_valid_q)
		else $error("sequencer finished without a result");
`endif

endmodule
